// ===== rtl/xce_pkg.sv =====
// ----------------------------------------------------------------------------
// xce_pkg
// Shared types, constants and character tables for the XML character escaper.
// ----------------------------------------------------------------------------
package xce_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] ASCII_MAX = 8'd127;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QUOT   = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    typedef enum logic [2:0] {
        KIND_PLAIN,
        KIND_AMP,
        KIND_LT,
        KIND_GT,
        KIND_QUOT,
        KIND_NUMREF
    } kind_t;

    // One classified input byte, ready to be expanded into characters.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] raw;
        logic [1:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
    } desc_t;

    // Position of the final character in the run for each class.
    function automatic logic [2:0] last_idx(input kind_t kind);
        logic [2:0] idx;
        begin
            case (kind)
                KIND_PLAIN:  idx = 3'd0;
                KIND_AMP:    idx = 3'd4;
                KIND_LT:     idx = 3'd3;
                KIND_GT:     idx = 3'd3;
                KIND_QUOT:   idx = 3'd5;
                KIND_NUMREF: idx = 3'd5;
                default:     idx = 3'd0;
            endcase
            return idx;
        end
    endfunction

    function automatic logic [7:0] char_at(input desc_t d, input logic [2:0] idx);
        logic [7:0] ch;
        begin
            ch = CH_SEMI;
            case (d.kind)
                KIND_PLAIN: ch = d.raw;
                KIND_AMP:
                begin
                    case (idx)
                        3'd0:    ch = CH_AMP;
                        3'd1:    ch = "a";
                        3'd2:    ch = "m";
                        3'd3:    ch = "p";
                        default: ch = CH_SEMI;
                    endcase
                end
                KIND_LT:
                begin
                    case (idx)
                        3'd0:    ch = CH_AMP;
                        3'd1:    ch = "l";
                        3'd2:    ch = "t";
                        default: ch = CH_SEMI;
                    endcase
                end
                KIND_GT:
                begin
                    case (idx)
                        3'd0:    ch = CH_AMP;
                        3'd1:    ch = "g";
                        3'd2:    ch = "t";
                        default: ch = CH_SEMI;
                    endcase
                end
                KIND_QUOT:
                begin
                    case (idx)
                        3'd0:    ch = CH_AMP;
                        3'd1:    ch = "q";
                        3'd2:    ch = "u";
                        3'd3:    ch = "o";
                        3'd4:    ch = "t";
                        default: ch = CH_SEMI;
                    endcase
                end
                KIND_NUMREF:
                begin
                    case (idx)
                        3'd0:    ch = CH_AMP;
                        3'd1:    ch = CH_HASH;
                        3'd2:    ch = CH_ZERO + {6'd0, d.hund};
                        3'd3:    ch = CH_ZERO + {4'd0, d.tens};
                        3'd4:    ch = CH_ZERO + {4'd0, d.ones};
                        default: ch = CH_SEMI;
                    endcase
                end
                default: ch = d.raw;
            endcase
            return ch;
        end
    endfunction

endpackage

// ===== rtl/xce_front.sv =====
// ----------------------------------------------------------------------------
// xce_front
// Classifies each input byte and splits high bytes into decimal digits.
// ----------------------------------------------------------------------------
module xce_front
(
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_byte,
    output logic           push,
    output xce_pkg::desc_t push_desc,
    input  logic           queue_full
);

    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    // High bytes lie in 128..255: hundreds digit is 1 or 2.
    always_comb
    begin
        if (in_byte >= 8'd200)
        begin
            rem = 7'(in_byte - 8'd200);
        end
        else
        begin
            rem = 7'(in_byte - 8'd100);
        end
        // rem * 205 / 2048 equals rem / 10 for rem below 100
        prod     = {8'd0, rem} * 15'd205;
        tens     = prod[14:11];
        tens_x10 = {3'd0, tens} * 7'd10;
    end

    always_comb
    begin
        push_desc.raw  = in_byte;
        push_desc.hund = (in_byte >= 8'd200) ? 2'd2 : 2'd1;
        push_desc.tens = tens;
        push_desc.ones = 4'(rem - tens_x10);
        if (in_byte > xce_pkg::ASCII_MAX)
        begin
            push_desc.kind = xce_pkg::KIND_NUMREF;
        end
        else if (in_byte == xce_pkg::CH_AMP)
        begin
            push_desc.kind = xce_pkg::KIND_AMP;
        end
        else if (in_byte == xce_pkg::CH_LT)
        begin
            push_desc.kind = xce_pkg::KIND_LT;
        end
        else if (in_byte == xce_pkg::CH_GT)
        begin
            push_desc.kind = xce_pkg::KIND_GT;
        end
        else if (in_byte == xce_pkg::CH_QUOT)
        begin
            push_desc.kind = xce_pkg::KIND_QUOT;
        end
        else
        begin
            push_desc.kind = xce_pkg::KIND_PLAIN;
        end
    end

endmodule

// ===== rtl/xce_queue.sv =====
// ----------------------------------------------------------------------------
// xce_queue
// Short descriptor queue between the classifier and the character emitter.
// ----------------------------------------------------------------------------
module xce_queue
#(
    parameter int unsigned DEPTH = xce_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  xce_pkg::desc_t push_desc,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output xce_pkg::desc_t pop_desc
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    xce_pkg::desc_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_desc  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== rtl/xce_back.sv =====
// ----------------------------------------------------------------------------
// xce_back
// Expands one descriptor into its character run, one character per cycle while the output is ready.
// ----------------------------------------------------------------------------
module xce_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           desc_valid,
    input  xce_pkg::desc_t desc,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_char,
    output logic           run_last
);

    xce_pkg::desc_t cur_reg;
    xce_pkg::desc_t cur_next;
    logic           cur_valid_reg;
    logic           cur_valid_next;
    logic [2:0]     idx_reg;
    logic [2:0]     idx_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [7:0]     out_char_reg;
    logic [7:0]     out_char_next;
    logic           run_last_reg;
    logic           run_last_next;
    logic           advance;
    logic           at_last;

    assign advance = cur_valid_reg && (!out_valid_reg || out_ready);
    assign at_last = (idx_reg == xce_pkg::last_idx(cur_reg.kind));
    // Refill the working descriptor when none is held or as its final character leaves.
    assign pop     = desc_valid && (!cur_valid_reg || (advance && at_last));

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign run_last  = run_last_reg;

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        run_last_next  = run_last_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
            out_char_next  = xce_pkg::char_at(cur_reg, idx_reg);
            run_last_next  = at_last;
            idx_next       = idx_reg + 3'd1;
            if (at_last)
            begin
                cur_valid_next = 1'b0;
            end
        end

        if (pop)
        begin
            cur_next       = desc;
            cur_valid_next = 1'b1;
            idx_next       = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_char_reg <= out_char_next;
        run_last_reg <= run_last_next;
    end

endmodule

// ===== rtl/xml_character_escaper_unit.sv =====
// ----------------------------------------------------------------------------
// xml_character_escaper_unit
// Escapes text bytes for XML: entities for & < > " and numeric references
// for bytes above 127; other bytes pass through.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake           | Payload
// input   | in        | in_valid / in_ready | in_byte[7:0]
// output  | out       | out_valid/out_ready | out_char[7:0], run_last
//
// Each byte yields a run of 1 to 6 characters, one per cycle from the output
// register while the output is ready; the emitter is the limit (run length
// 1 plain, 4 for < >, 5 for &, 6 for " and high bytes). A byte is held in
// the queue, then the working descriptor, before its characters are emitted.
// A QUEUE_DEPTH descriptor queue lets the input keep flowing while a run is
// emitted or the output stalls. Reset clears the queue and output valid.
// ----------------------------------------------------------------------------
module xml_character_escaper_unit
#(
    parameter int unsigned QUEUE_DEPTH = xce_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char,
    output logic       run_last
);

    logic           push;
    xce_pkg::desc_t push_desc;
    logic           queue_full;
    logic           pop;
    logic           desc_valid;
    xce_pkg::desc_t pop_desc;

    xce_front u_front
    (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .push       (push),
        .push_desc  (push_desc),
        .queue_full (queue_full)
    );

    xce_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (desc_valid),
        .pop_desc  (pop_desc)
    );

    xce_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc_valid),
        .desc       (pop_desc),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .run_last   (run_last)
    );

endmodule

// ===== rtl/xce_checker.sv =====
// ----------------------------------------------------------------------------
// xce_checker
// Port-level checks on the escaped character stream.
// ----------------------------------------------------------------------------
module xce_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       run_last
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(run_last))
        else $error("output changed while stalled");

    // High bytes and the characters < > " never leave raw.
    a_no_raw_special: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_char[7] == 1'b0 && out_char != xce_pkg::CH_LT
            && out_char != xce_pkg::CH_GT && out_char != xce_pkg::CH_QUOT)
        else $error("unescaped character on output");

    a_amp_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_last |-> out_char != xce_pkg::CH_AMP)
        else $error("run ends on ampersand");

    // A semicolon inside a run only ever closes it.
    a_semi_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> out_char != xce_pkg::CH_SEMI)
        else $error("semicolon in the middle of a run");

    // The first character after a completed run must open a new one legally.
    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && run_last ##1 out_valid && !run_last
            |-> out_char == xce_pkg::CH_AMP)
        else $error("multi-character run does not start with ampersand");

endmodule

bind xml_character_escaper_unit xce_checker u_xce_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .run_last  (run_last)
);
